// File: rtl/gdm_pkg.sv
// ----------------------------------------------------------------------------
// gdm_pkg
// Shared types and constants for the graph dominator matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package gdm_pkg;

  localparam int unsigned GdmMaxNodes = 64;
  localparam int unsigned GdmLaneW    = 2;
  localparam int unsigned GdmLanes    = 1 << GdmLaneW;
  localparam int unsigned GdmRowW     = 64;
  localparam int unsigned GdmNodeW    = 6;
  localparam int unsigned GdmCountW   = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } gdm_state_e;

  // Which nodes a lane may expand during the current pass.
  typedef struct packed {
    logic [GdmCountW-1:0] n;
    logic [GdmNodeW-1:0]  blk;
    logic                 blk_en;
  } gdm_gate_t;

endpackage

`default_nettype wire

// File: rtl/graph_dominator_matrix.sv
// ----------------------------------------------------------------------------
// graph_dominator_matrix
// Dominator rows of a directed graph by removing one node at a time.
// ----------------------------------------------------------------------------
// A load request is stored when accepted; loads are taken back to back while
// idle. A compute request runs n+1 reachability passes (n = node_count), each
// repeating sweeps over the ceil(n/4) groups until a sweep adds no node, so
// a pass takes up to about (graph depth + 2) sweeps; each dominator row then
// waits for a free output register. The four lanes with one memory read port
// each set the sweep length. Reset is asynchronous and active low; it clears
// the control state and node_count to 1. Adjacency rows hold garbage until loaded.
`default_nettype none

module graph_dominator_matrix #(
  parameter int unsigned MAX_NODES = gdm_pkg::GdmMaxNodes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gdm_pkg::GdmCountW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [gdm_pkg::GdmNodeW-1:0]  row_node_i,
  input  wire logic [gdm_pkg::GdmRowW-1:0]   edge_bits_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [gdm_pkg::GdmNodeW-1:0]  dominator_node_o,
  output logic      [gdm_pkg::GdmRowW-1:0]   dominated_bits_o,
  output logic                               last_row_o
);
  import gdm_pkg::*;

  localparam int unsigned Depth = (MAX_NODES + GdmLanes - 1) / GdmLanes;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  gdm_state_e state_q, state_d;

  logic [GdmCountW-1:0] cfg_n_q;
  logic [GdmCountW-1:0] n;
  logic [GdmCountW-1:0] ngrp;
  logic [GdmRowW-1:0]   mask;

  // Sweep control: group issue counter and registered read pipeline flags.
  logic             iss_q, iss_d;
  logic [AddrW-1:0] grp_q, grp_d;
  logic             rv_q, rv_d, rl_q, rl_d;
  logic             chg_q, chg_d;
  logic             first_q, first_d;
  logic [GdmNodeW-1:0] blk_q, blk_d;

  logic [GdmRowW-1:0] seen_q, seen_d;
  logic [GdmRowW-1:0] reach_q, reach_d;
  logic [GdmRowW-1:0] dom_q, dom_d;

  logic                out_valid_q, out_valid_d;
  logic [GdmNodeW-1:0] out_node_q, out_node_d;
  logic [GdmRowW-1:0]  out_bits_q, out_bits_d;
  logic                out_last_q, out_last_d;

  logic               in_acc, start, load_we;
  logic               grp_last, pass_done, out_free, blk_last;
  logic [GdmRowW-1:0] fresh;
  logic [GdmRowW-1:0] rows [GdmLanes];
  gdm_gate_t          gate;

  // node_count is clamped to 1..MAX_NODES.
  always_comb begin
    if (cfg_n_q == '0) begin
      n = GdmCountW'(1);
    end else if (cfg_n_q > GdmCountW'(MAX_NODES)) begin
      n = GdmCountW'(MAX_NODES);
    end else begin
      n = cfg_n_q;
    end
  end

  assign ngrp = (n + GdmCountW'(GdmLanes - 1)) >> GdmLaneW;
  assign mask = ~({GdmRowW{1'b1}} << n);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && action_i;
  assign load_we    = in_acc && !action_i && (GdmCountW'(row_node_i) < GdmCountW'(MAX_NODES));

  assign gate.n      = n;
  assign gate.blk    = blk_q;
  assign gate.blk_en = !first_q;

  // The lanes: lane l owns the nodes whose low index bits equal l.
  for (genvar l = 0; l < GdmLanes; l++) begin : g_lane
    gdm_lane #(
      .MAX_NODES (MAX_NODES),
      .LANE_ID   (l)
    ) u_lane (
      .clk_i   (clk_i),
      .we_i    (load_we && (row_node_i[GdmLaneW-1:0] == GdmLaneW'(l))),
      .waddr_i (AddrW'(row_node_i >> GdmLaneW)),
      .wdata_i (edge_bits_i),
      .raddr_i (grp_q),
      .gate_i  (gate),
      .seen_i  (seen_q),
      .row_o   (rows[l])
    );
  end

  gdm_merge u_merge (
    .rows_i  (rows),
    .seen_i  (seen_q),
    .mask_i  (mask),
    .fresh_o (fresh)
  );

  assign grp_last  = (GdmCountW'(grp_q) == ngrp - GdmCountW'(1));
  // A pass ends after a full sweep in which no node was added.
  assign pass_done = rv_q && rl_q && !chg_q && (fresh == '0);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign blk_last  = (GdmCountW'(blk_q) == n - GdmCountW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (pass_done && !first_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = blk_last ? ST_IDLE : ST_SWEEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    iss_d       = iss_q;
    grp_d       = grp_q;
    rv_d        = iss_q;
    rl_d        = iss_q && grp_last;
    chg_d       = chg_q;
    first_d     = first_q;
    blk_d       = blk_q;
    seen_d      = seen_q;
    reach_d     = reach_q;
    dom_d       = dom_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_node_d  = out_node_q;
    out_bits_d  = out_bits_q;
    out_last_d  = out_last_q;

    if (iss_q) begin
      if (grp_last) begin
        iss_d = 1'b0;
      end else begin
        grp_d = grp_q + AddrW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          first_d = 1'b1;
          blk_d   = '0;
          seen_d  = GdmRowW'(1);
          iss_d   = 1'b1;
          grp_d   = '0;
          chg_d   = 1'b0;
        end
      end
      ST_SWEEP: begin
        if (rv_q) begin
          seen_d = seen_q | fresh;
          chg_d  = chg_q || (fresh != '0);
          if (rl_q) begin
            chg_d = 1'b0;
            if (!pass_done) begin
              // Something was added: sweep again.
              iss_d = 1'b1;
              grp_d = '0;
            end else if (first_q) begin
              // Reachable set found; start the pass with node 0 blocked.
              reach_d = seen_q;
              first_d = 1'b0;
              seen_d  = GdmRowW'(1);
              iss_d   = 1'b1;
              grp_d   = '0;
            end else begin
              dom_d = ((reach_q & ~seen_q) | (reach_q & (GdmRowW'(1) << blk_q))) & mask;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_node_d  = blk_q;
          out_bits_d  = dom_q;
          out_last_d  = blk_last;
          if (!blk_last) begin
            blk_d  = blk_q + GdmNodeW'(1);
            seen_d = GdmRowW'(1);
            iss_d  = 1'b1;
            grp_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_n_q     <= GdmCountW'(1);
      iss_q       <= 1'b0;
      grp_q       <= '0;
      rv_q        <= 1'b0;
      rl_q        <= 1'b0;
      chg_q       <= 1'b0;
      first_q     <= 1'b0;
      blk_q       <= '0;
      seen_q      <= '0;
      reach_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      grp_q       <= grp_d;
      rv_q        <= rv_d;
      rl_q        <= rl_d;
      chg_q       <= chg_d;
      first_q     <= first_d;
      blk_q       <= blk_d;
      seen_q      <= seen_d;
      reach_q     <= reach_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_n_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dom_q      <= dom_d;
    out_node_q <= out_node_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign dominator_node_o = out_node_q;
  assign dominated_bits_o = out_bits_q;
  assign last_row_o       = out_last_q;

endmodule

`default_nettype wire

// File: rtl/gdm_lane.sv
// ----------------------------------------------------------------------------
// gdm_lane
// One lane: holds the adjacency rows of every GdmLanes-th node and returns
// the row of its node when that node may be expanded.
// ----------------------------------------------------------------------------
`default_nettype none

module gdm_lane #(
  parameter int unsigned MAX_NODES = gdm_pkg::GdmMaxNodes,
  parameter int unsigned LANE_ID   = 0,
  localparam int unsigned Depth    = (MAX_NODES + gdm_pkg::GdmLanes - 1) / gdm_pkg::GdmLanes,
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AddrW-1:0]            waddr_i,
  input  wire logic [gdm_pkg::GdmRowW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]            raddr_i,
  input  wire gdm_pkg::gdm_gate_t          gate_i,
  input  wire logic [gdm_pkg::GdmRowW-1:0] seen_i,
  output logic      [gdm_pkg::GdmRowW-1:0] row_o
);
  import gdm_pkg::*;

  logic [GdmRowW-1:0]   mem_q [Depth];
  logic [GdmRowW-1:0]   rdata_q;
  logic [AddrW-1:0]     raddr_q;
  logic [GdmCountW-1:0] node;
  logic                 expand;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
    raddr_q <= raddr_i;
  end

  // Node whose row is in the read register.
  assign node   = (GdmCountW'(raddr_q) << GdmLaneW) | GdmCountW'(LANE_ID);
  assign expand = (node < gate_i.n) && seen_i[node[GdmNodeW-1:0]] &&
                  !(gate_i.blk_en && (node[GdmNodeW-1:0] == gate_i.blk));
  assign row_o  = expand ? rdata_q : '0;

endmodule

`default_nettype wire

// File: rtl/gdm_merge.sv
// ----------------------------------------------------------------------------
// gdm_merge
// Combines the rows of all lanes into the set of newly reached nodes.
// ----------------------------------------------------------------------------
`default_nettype none

module gdm_merge (
  input  wire logic [gdm_pkg::GdmRowW-1:0] rows_i [gdm_pkg::GdmLanes],
  input  wire logic [gdm_pkg::GdmRowW-1:0] seen_i,
  input  wire logic [gdm_pkg::GdmRowW-1:0] mask_i,
  output logic      [gdm_pkg::GdmRowW-1:0] fresh_o
);
  import gdm_pkg::*;

  logic [GdmRowW-1:0] acc;

  always_comb begin
    acc = '0;
    for (int unsigned l = 0; l < GdmLanes; l++) begin
      acc = acc | rows_i[l];
    end
    fresh_o = acc & mask_i & ~seen_i;
  end

endmodule

`default_nettype wire

// File: rtl/gdm_checker.sv
// ----------------------------------------------------------------------------
// gdm_checker
// Port-level checks for the graph dominator matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module gdm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [5:0]  dominator_node_o,
  input wire logic [63:0] dominated_bits_o,
  input wire logic        last_row_o
);

  // A stalled request keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(dominated_bits_o) &&
    $stable(dominator_node_o) && $stable(last_row_o))
    else $error("output request changed while stalled");

  // A node that dominates anything dominates itself.
  a_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (dominated_bits_o != '0) |-> dominated_bits_o[dominator_node_o])
    else $error("dominator row lacks its own node");

  // The start node is always reachable, so it dominates itself.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (dominator_node_o == 6'd0) |-> dominated_bits_o[0])
    else $error("start row does not cover the start node");

endmodule

bind graph_dominator_matrix gdm_checker u_gdm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .dominator_node_o (dominator_node_o),
  .dominated_bits_o (dominated_bits_o),
  .last_row_o       (last_row_o)
);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_dominator_matrix. Adjacency rows are loaded
// and compute requests are issued, first from a short table, then as random
// phases. Each phase uses its own node count, including zero, one, the full
// 64 and values above 64. Every result row is checked against typed rows or a
// predictor that removes one node at a time and tracks what node 0 reaches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdm_pkg::*;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;
  localparam int   STALL_PCT   = 15;
  localparam int   IDLE_LIMIT  = 40000;
  localparam int   RAND_ITEMS  = 300;

  typedef struct {
    logic [GdmNodeW-1:0] node;
    logic [GdmRowW-1:0]  bits;
    logic                last;
  } dom_row_t;

  typedef struct {
    bit                    cfg_en;
    logic [GdmCountW-1:0]  cfg_val;
    logic                  act;
    logic [GdmNodeW-1:0]   row;
    logic [GdmRowW-1:0]    edges;
    int                    ntyped;
    logic [3:0][GdmRowW-1:0] typed;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [GdmCountW-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 action_i;
  logic [GdmNodeW-1:0]  row_node_i;
  logic [GdmRowW-1:0]   edge_bits_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [GdmNodeW-1:0]  dominator_node_o;
  logic [GdmRowW-1:0]   dominated_bits_o;
  logic                 last_row_o;

  // Predictor state: our own copy of the graph and the node count.
  logic [GdmRowW-1:0]   adj_mem [GdmMaxNodes];
  bit                   row_loaded [GdmMaxNodes];
  logic [GdmCountW-1:0] node_count_q;
  dom_row_t             dom_rows_q [$];

  int  mismatches;
  int  idle_cycles;
  int  cyc;
  int  stim_count;
  bit  quiet;

  graph_dominator_matrix u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .row_node_i       (row_node_i),
    .edge_bits_i      (edge_bits_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dominator_node_o (dominator_node_o),
    .dominated_bits_o (dominated_bits_o),
    .last_row_o       (last_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The bench runs a stretch with no idling on either side in the middle of
  // the run; outside of it both sides idle at random.
  assign quiet = (cyc >= 4000) && (cyc < 12000);

  // Reachable set from node 0 where node blk may be entered but is never
  // expanded. A blk at or above n blocks nothing.
  function automatic logic [GdmRowW-1:0] reach_from_start(int unsigned n, int unsigned blk,
                                                          logic [GdmRowW-1:0] mask);
    logic [GdmRowW-1:0] seen;
    logic [GdmRowW-1:0] front;
    logic [GdmRowW-1:0] nxt;
    seen  = 64'h1;
    front = 64'h1;
    while (front != '0) begin
      nxt = '0;
      for (int k = 0; k < n; k++) begin
        if (front[k] && k != blk) nxt |= adj_mem[k];
      end
      nxt &= mask & ~seen;
      seen |= nxt;
      front = nxt;
    end
    return seen;
  endfunction

  function automatic int unsigned active_nodes(logic [GdmCountW-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > GdmMaxNodes) return GdmMaxNodes;
    return 32'(cnt);
  endfunction

  // Pushes one expected dominator row per node for a compute request.
  function automatic void predict_dominators();
    int unsigned        n;
    logic [GdmRowW-1:0] mask;
    logic [GdmRowW-1:0] reach_all;
    logic [GdmRowW-1:0] reach_blk;
    dom_row_t           r;
    n    = active_nodes(node_count_q);
    mask = (n >= 64) ? '1 : ((64'h1 << n) - 64'h1);
    reach_all = reach_from_start(n, 64, mask);
    for (int unsigned d = 0; d < n; d++) begin
      reach_blk = reach_from_start(n, d, mask);
      r.node = d[GdmNodeW-1:0];
      r.bits = ((reach_all & ~reach_blk) | (reach_all & (64'h1 << d))) & mask;
      r.last = (d + 1 == n);
      dom_rows_q.push_back(r);
    end
  endfunction

  // Drops the request valid and waits until every expected row is out, then
  // lets the block settle before the caller touches the register.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (dom_rows_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_node_count(logic [GdmCountW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    node_count_q = val;
  endtask

  // Presents one request, waits for it to be taken, and updates the
  // predictor. Typed rows, where given, replace the predicted ones.
  task automatic send_request(logic act, logic [GdmNodeW-1:0] row, logic [GdmRowW-1:0] edges,
                              int ntyped, logic [3:0][GdmRowW-1:0] typed);
    dom_row_t r;
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    row_node_i  <= row;
    edge_bits_i <= edges;
    do @(posedge clk_i); while (in_stall_o);
    stim_count++;
    if (act == ACT_LOAD) begin
      adj_mem[row]    = edges;
      row_loaded[row] = 1'b1;
    end else if (ntyped > 0) begin
      for (int i = 0; i < ntyped; i++) begin
        r.node = i[GdmNodeW-1:0];
        r.bits = typed[i];
        r.last = (i == ntyped - 1);
        dom_rows_q.push_back(r);
      end
    end else begin
      predict_dominators();
    end
  endtask

  // Edge rows in several flavors so that both long chains and dense graphs
  // come up.
  function automatic logic [GdmRowW-1:0] random_edges(logic [GdmNodeW-1:0] row);
    logic [GdmRowW-1:0] a;
    logic [GdmRowW-1:0] b;
    logic [GdmRowW-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return a;
      1:       return '1;
      2:       return 64'h1 << (row + 1);
      3:       return (64'h1 << (row + 1)) | (a & b & c);
      default: return a & b & c;
    endcase
  endfunction

  // Output side: random stall, then sampling and checking of each result.
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk_i) begin
    dom_row_t exp_row;
    cyc <= cyc + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (dom_rows_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected dominator row: node %0d bits %h last %b",
                   dominator_node_o, dominated_bits_o, last_row_o);
      end else begin
        exp_row = dom_rows_q.pop_front();
        if (dominator_node_o !== exp_row.node || dominated_bits_o !== exp_row.bits ||
            last_row_o !== exp_row.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dominator row mismatch: exp node %0d bits %h last %b, got node %0d bits %h last %b",
                     exp_row.node, exp_row.bits, exp_row.last,
                     dominator_node_o, dominated_bits_o, last_row_o);
        end
      end
    end
  end

  // Watchdog: ends the run after a long time in which no request or result
  // is accepted.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [18];
    logic [GdmCountW-1:0] nc;
    int unsigned          neff;
    int                   big_left;
    int                   extra;
    logic [GdmNodeW-1:0]  r;

    // Node count extremes, chains, a diamond, an unreachable tail, an
    // isolated start, and edge bits above the node count that must be ignored.
    dir_tab = '{
      '{0, 0, ACT_LOAD,    0,  {64{1'b1}},             0, '0},
      '{0, 0, ACT_COMPUTE, 0,  64'h0,                  1, {64'h0, 64'h0, 64'h0, 64'h1}},
      '{0, 0, ACT_LOAD,    63, 64'hA5A5_5A5A_F00F_0FF0, 0, '0},
      '{1, 4, ACT_LOAD,    0,  64'h2,                  0, '0},
      '{0, 0, ACT_LOAD,    1,  64'h4,                  0, '0},
      '{0, 0, ACT_LOAD,    2,  64'h8,                  0, '0},
      '{0, 0, ACT_LOAD,    3,  64'hFFFF_FFFF_FFFF_FFF1, 0, '0},
      '{0, 0, ACT_COMPUTE, 0,  64'h0,                  4, {64'h8, 64'hC, 64'hE, 64'hF}},
      '{0, 0, ACT_LOAD,    1,  64'h0,                  0, '0},
      '{0, 0, ACT_COMPUTE, 63, {64{1'b1}},             4, {64'h0, 64'h0, 64'h2, 64'h3}},
      '{1, 0, ACT_COMPUTE, 0,  64'h0,                  1, {64'h0, 64'h0, 64'h0, 64'h1}},
      '{1, 4, ACT_LOAD,    0,  64'h6,                  0, '0},
      '{0, 0, ACT_LOAD,    1,  64'h8,                  0, '0},
      '{0, 0, ACT_LOAD,    2,  64'h8,                  0, '0},
      '{0, 0, ACT_LOAD,    3,  64'h0,                  0, '0},
      '{0, 0, ACT_COMPUTE, 0,  64'h0,                  0, '0},
      '{1, 1, ACT_LOAD,    0,  64'h0,                  0, '0},
      '{0, 0, ACT_COMPUTE, 0,  64'h0,                  1, {64'h0, 64'h0, 64'h0, 64'h1}}
    };

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    action_i     = ACT_LOAD;
    row_node_i   = '0;
    edge_bits_i  = '0;
    out_stall_i  = 1'b0;
    cyc          = 0;
    mismatches   = 0;
    idle_cycles  = 0;
    stim_count   = 0;
    node_count_q = 1;
    big_left     = 3;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_en) write_node_count(dir_tab[i].cfg_val);
      send_request(dir_tab[i].act, dir_tab[i].row, dir_tab[i].edges,
                   dir_tab[i].ntyped, dir_tab[i].typed);
    end

    // Random phases: each picks a node count, makes sure every row the
    // compute may read has been loaded, adds random loads, and computes.
    stim_count = 0;
    while (stim_count < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       nc = 0;
        1:       nc = 127;
        2:       nc = 64;
        3:       nc = 7'($urandom_range(65, 126));
        4:       nc = 7'($urandom_range(9, 20));
        default: nc = 7'($urandom_range(1, 8));
      endcase
      if (active_nodes(nc) > 20) begin
        if (big_left > 0) big_left--;
        else nc = 7'($urandom_range(1, 8));
      end
      write_node_count(nc);
      neff = active_nodes(nc);
      for (int unsigned k = 0; k < neff; k++) begin
        if (!row_loaded[k] || $urandom_range(0, 3) == 0)
          send_request(ACT_LOAD, k[GdmNodeW-1:0], random_edges(k[GdmNodeW-1:0]), 0, '0);
      end
      extra = $urandom_range(0, 4);
      for (int k = 0; k < extra; k++) begin
        // Mostly rows in use; sometimes rows above the node count.
        r = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, neff - 1));
        send_request(ACT_LOAD, r, random_edges(r), 0, '0);
      end
      // A compute request carries don't-care row and edge fields.
      send_request(ACT_COMPUTE, 6'($urandom_range(0, 63)), {$urandom, $urandom}, 0, '0);
      if ($urandom_range(0, 4) == 0)
        send_request(ACT_COMPUTE, 6'($urandom_range(0, 63)), {$urandom, $urandom}, 0, '0);
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && dom_rows_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
